>>> rtl/quaternion_to_euler_levels_macros.svh
// Assertion macros shared by the quaternion to Euler level block.
`ifndef QUATERNION_TO_EULER_LEVELS_MACROS_SVH
`define QUATERNION_TO_EULER_LEVELS_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define Q2E_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("q2e: assertion failed");

// Next-cycle implication, checked while out of reset.
`define Q2E_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("q2e: assertion failed");

`endif

>>> rtl/q2e_pkg.sv
// Shared widths, constants and types for the quaternion to Euler level block.
package q2e_pkg;

    localparam int QUAT_W          = 16;
    localparam int PROD_W          = 32;
    localparam int SUM_W           = 34;
    localparam int T_W             = 30;
    localparam int AT_W            = 29;
    localparam int RAD_W           = 57;
    localparam int ROOT_W          = 29;
    localparam int XW              = 37;
    localparam int ZW              = 20;
    localparam int ANG_W           = 16;
    localparam int LIM_W           = 15;
    localparam int PLIM_W          = 14;
    localparam int DIFF_W          = 15;
    localparam int LEVEL_W         = 7;
    localparam int CORDIC_STEPS    = 16;
    localparam int LEVEL_SCALE_DEF = 100;
    localparam int CFG_IDX_W       = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ROLL_LO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROLL_HI  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_LO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_HI = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_LO   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_HI   = 3'd5;

    localparam logic signed [SUM_W-1:0] ONE_Q28 = 34'sd268435456;
    localparam logic [RAD_W-1:0] ONE_Q56 = {1'b1, {(RAD_W-1){1'b0}}};
    localparam logic signed [ZW-1:0] HALF_PI_Q16 = 20'sd102944;

    localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150,
        20'sd4091,  20'sd2047,  20'sd1024,  20'sd512,
        20'sd256,   20'sd128,   20'sd64,    20'sd32,
        20'sd16,    20'sd8,     20'sd4,     20'sd2
    };

    typedef struct packed {
        logic signed [SUM_W-1:0] roll_num;
        logic signed [SUM_W-1:0] roll_den;
        logic signed [SUM_W-1:0] yaw_num;
        logic signed [SUM_W-1:0] yaw_den;
        logic signed [T_W-1:0]   pitch_t;
    } t_front;

    typedef struct packed {
        logic signed [LIM_W-1:0]  roll_lo;
        logic signed [LIM_W-1:0]  roll_hi;
        logic signed [PLIM_W-1:0] pitch_lo;
        logic signed [PLIM_W-1:0] pitch_hi;
        logic signed [LIM_W-1:0]  yaw_lo;
        logic signed [LIM_W-1:0]  yaw_hi;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        roll_lo:  -15'sd4506,
        roll_hi:   15'sd4506,
        pitch_lo: -14'sd1229,
        pitch_hi:  14'sd2867,
        yaw_lo:   -15'sd6144,
        yaw_hi:   -15'sd819
    };

    typedef enum logic [1:0] {
        WIN_LOW = 2'd0,
        WIN_TOP = 2'd1,
        WIN_DIV = 2'd2
    } t_win;

endpackage

>>> rtl/quaternion_to_euler_levels.sv
// Top level: quaternion in, roll, pitch and yaw control levels out.
//
// A request is taken at each rising edge where start is high; busy stays low,
// so a new quaternion may be issued in every cycle. Each request gives one
// result: o_done is high for exactly one cycle with the three levels on
// o_roll_level, o_pitch_level and o_yaw_level, in request order.
// The pipeline holds 3 front-end stages, 29 square-root stages (one per root bit),
// 18 CORDIC stages, and the window, scaling and output stages around one
// divider stage per quotient bit.
// Throughput is one request per cycle.
// The six window limits are written through i_cfg_we, i_cfg_index and
// i_cfg_data, and should change only while no request is in flight.
// Reset clears the pipeline valid bits and restores the default windows.
// Results cannot be held off by the receiver; they must be taken when shown.
`include "quaternion_to_euler_levels_macros.svh"
module quaternion_to_euler_levels #(
    parameter int LEVEL_SCALE = q2e_pkg::LEVEL_SCALE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_cfg_we,
    input  logic [q2e_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [q2e_pkg::LIM_W-1:0]           i_cfg_data,
    input  logic signed [q2e_pkg::QUAT_W-1:0]   i_quat_w,
    input  logic signed [q2e_pkg::QUAT_W-1:0]   i_quat_x,
    input  logic signed [q2e_pkg::QUAT_W-1:0]   i_quat_y,
    input  logic signed [q2e_pkg::QUAT_W-1:0]   i_quat_z,
    output logic                                o_done,
    output logic [q2e_pkg::LEVEL_W-1:0]         o_roll_level,
    output logic [q2e_pkg::LEVEL_W-1:0]         o_pitch_level,
    output logic [q2e_pkg::LEVEL_W-1:0]         o_yaw_level
);
    import q2e_pkg::*;

    localparam int SW      = $clog2(LEVEL_SCALE + 1);
    localparam int LATENCY = 3 + ROOT_W + CORDIC_STEPS + 2 + SW + 3;

    t_cfg                    r_cfg;
    logic                    w_accept;
    logic                    w_front_vld, w_sq_vld;
    t_front                  w_front_side, w_sq_side;
    logic [RAD_W-1:0]        w_sq;
    logic [ROOT_W-1:0]       w_root;
    logic                    w_roll_cvld, w_pitch_cvld, w_yaw_cvld;
    logic signed [ANG_W-1:0] w_roll_ang, w_pitch_ang, w_yaw_ang;
    logic                    w_roll_vld, w_pitch_vld, w_yaw_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ROLL_LO:  r_cfg.roll_lo  <= i_cfg_data;
                REG_ROLL_HI:  r_cfg.roll_hi  <= i_cfg_data;
                REG_PITCH_LO: r_cfg.pitch_lo <= i_cfg_data[PLIM_W-1:0];
                REG_PITCH_HI: r_cfg.pitch_hi <= i_cfg_data[PLIM_W-1:0];
                REG_YAW_LO:   r_cfg.yaw_lo   <= i_cfg_data;
                REG_YAW_HI:   r_cfg.yaw_hi   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    q2e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_accept),
        .i_w     (i_quat_w),
        .i_x     (i_quat_x),
        .i_y     (i_quat_y),
        .i_z     (i_quat_z),
        .o_vld   (w_front_vld),
        .o_side  (w_front_side),
        .o_sq    (w_sq)
    );

    q2e_isqrt #(
        .NW     (RAD_W),
        .SIDE_W ($bits(t_front))
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_front_vld),
        .i_rad   (ONE_Q56 - w_sq),
        .i_side  (w_front_side),
        .o_vld   (w_sq_vld),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    q2e_cordic u_roll_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_sq_vld),
        .i_x     (XW'(w_sq_side.roll_den)),
        .i_y     (XW'(w_sq_side.roll_num)),
        .o_vld   (w_roll_cvld),
        .o_ang   (w_roll_ang)
    );

    q2e_cordic u_pitch_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_sq_vld),
        .i_x     (XW'(signed'({1'b0, w_root}))),
        .i_y     (XW'(w_sq_side.pitch_t)),
        .o_vld   (w_pitch_cvld),
        .o_ang   (w_pitch_ang)
    );

    q2e_cordic u_yaw_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_sq_vld),
        .i_x     (XW'(w_sq_side.yaw_den)),
        .i_y     (XW'(w_sq_side.yaw_num)),
        .o_vld   (w_yaw_cvld),
        .o_ang   (w_yaw_ang)
    );

    q2e_level #(
        .LEVEL_SCALE (LEVEL_SCALE)
    ) u_roll_level (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_roll_cvld),
        .i_ang   (-w_roll_ang),
        .i_lo    (r_cfg.roll_lo),
        .i_hi    (r_cfg.roll_hi),
        .o_vld   (w_roll_vld),
        .o_level (o_roll_level)
    );

    q2e_level #(
        .LEVEL_SCALE (LEVEL_SCALE)
    ) u_pitch_level (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_pitch_cvld),
        .i_ang   (w_pitch_ang),
        .i_lo    (LIM_W'(r_cfg.pitch_lo)),
        .i_hi    (LIM_W'(r_cfg.pitch_hi)),
        .o_vld   (w_pitch_vld),
        .o_level (o_pitch_level)
    );

    q2e_level #(
        .LEVEL_SCALE (LEVEL_SCALE)
    ) u_yaw_level (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_yaw_cvld),
        .i_ang   (-w_yaw_ang),
        .i_lo    (r_cfg.yaw_lo),
        .i_hi    (r_cfg.yaw_hi),
        .o_vld   (w_yaw_vld),
        .o_level (o_yaw_level)
    );

    assign o_done = w_roll_vld;

    `Q2E_ASSERT_IMPL(a_lanes_aligned, w_roll_vld, w_pitch_vld && w_yaw_vld)
    `Q2E_ASSERT_IMPL(a_fixed_latency, o_done, $past(start && !busy, LATENCY))
    `Q2E_ASSERT_NEXT(a_cfg_index_ignored, i_cfg_we && (i_cfg_index > REG_YAW_HI), $stable(r_cfg))

endmodule

>>> rtl/q2e_front.sv
// Front end: quaternion products, atan2 operands, clamped asin term and its square.
module q2e_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_vld,
    input  logic signed [q2e_pkg::QUAT_W-1:0]    i_w,
    input  logic signed [q2e_pkg::QUAT_W-1:0]    i_x,
    input  logic signed [q2e_pkg::QUAT_W-1:0]    i_y,
    input  logic signed [q2e_pkg::QUAT_W-1:0]    i_z,
    output logic                                 o_vld,
    output q2e_pkg::t_front                      o_side,
    output logic [q2e_pkg::RAD_W-1:0]            o_sq
);
    import q2e_pkg::*;

    logic                     r_v1, r_v2, r_v3;
    logic signed [PROD_W-1:0] r_wx, r_yz, r_xx, r_yy, r_zz, r_wy, r_zx, r_wz, r_xy;
    t_front                   n_side2, r_side2, r_side3;
    logic signed [SUM_W-1:0]  n_t_full;
    logic [AT_W-1:0]          n_at;
    logic [2*AT_W-1:0]        n_sq;
    logic [RAD_W-1:0]         r_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wx <= i_w * i_x;
        r_yz <= i_y * i_z;
        r_xx <= i_x * i_x;
        r_yy <= i_y * i_y;
        r_zz <= i_z * i_z;
        r_wy <= i_w * i_y;
        r_zx <= i_z * i_x;
        r_wz <= i_w * i_z;
        r_xy <= i_x * i_y;
    end

    always_comb begin
        n_side2.roll_num = (SUM_W'(r_wx) + SUM_W'(r_yz)) <<< 1;
        n_side2.roll_den = ONE_Q28 - ((SUM_W'(r_xx) + SUM_W'(r_yy)) <<< 1);
        n_side2.yaw_num  = (SUM_W'(r_wz) + SUM_W'(r_xy)) <<< 1;
        n_side2.yaw_den  = ONE_Q28 - ((SUM_W'(r_yy) + SUM_W'(r_zz)) <<< 1);
        n_t_full         = (SUM_W'(r_wy) - SUM_W'(r_zx)) <<< 1;
        if (n_t_full > ONE_Q28) begin
            n_side2.pitch_t = T_W'(ONE_Q28);
        end else if (n_t_full < -ONE_Q28) begin
            n_side2.pitch_t = T_W'(-ONE_Q28);
        end else begin
            n_side2.pitch_t = T_W'(n_t_full);
        end
    end

    always_ff @(posedge i_clk) begin
        r_side2 <= n_side2;
    end

    always_comb begin
        if (r_side2.pitch_t[T_W-1]) begin
            n_at = AT_W'(-r_side2.pitch_t);
        end else begin
            n_at = AT_W'(r_side2.pitch_t);
        end
        n_sq = {{AT_W{1'b0}}, n_at} * {{AT_W{1'b0}}, n_at};
    end

    always_ff @(posedge i_clk) begin
        r_side3 <= r_side2;
        r_sq    <= n_sq[RAD_W-1:0];
    end

    assign o_vld  = r_v3;
    assign o_side = r_side3;
    assign o_sq   = r_sq;

endmodule

>>> rtl/q2e_isqrt.sv
// Pipelined floor square root, one result bit per stage, with a carried sideband.
module q2e_isqrt #(
    parameter int NW     = q2e_pkg::RAD_W,
    parameter int SIDE_W = $bits(q2e_pkg::t_front)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic [NW-1:0]           i_rad,
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_vld,
    output logic [(NW+1)/2-1:0]     o_root,
    output logic [SIDE_W-1:0]       o_side
);
    localparam int RW = (NW + 1) / 2;
    localparam int TW = 2 * RW + 1;

    logic              r_vld  [RW];
    logic [TW-1:0]     r_rem  [RW];
    logic [TW-1:0]     r_root [RW];
    logic [SIDE_W-1:0] r_side [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        localparam logic [TW-1:0] BIT = TW'(1) << (2 * (RW - 1 - k));
        logic              vld_in;
        logic [TW-1:0]     rem_in, root_in, trial, n_rem, n_root;
        logic [SIDE_W-1:0] side_in;

        if (k == 0) begin : g_first
            assign vld_in  = i_vld;
            assign rem_in  = TW'(i_rad);
            assign root_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign side_in = r_side[k-1];
        end

        always_comb begin
            trial = root_in + BIT;
            if (rem_in >= trial) begin
                n_rem  = rem_in - trial;
                n_root = (root_in >> 1) + BIT;
            end else begin
                n_rem  = rem_in;
                n_root = root_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_rem;
            r_root[k] <= n_root;
            r_side[k] <= side_in;
        end
    end

    assign o_vld  = r_vld[RW-1];
    assign o_root = r_root[RW-1][RW-1:0];
    assign o_side = r_side[RW-1];

endmodule

>>> rtl/q2e_cordic.sv
// Pipelined vectoring CORDIC atan2 with Q3.12 rounding of the angle.
module q2e_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_vld,
    input  logic signed [q2e_pkg::XW-1:0]     i_x,
    input  logic signed [q2e_pkg::XW-1:0]     i_y,
    output logic                              o_vld,
    output logic signed [q2e_pkg::ANG_W-1:0]  o_ang
);
    import q2e_pkg::*;

    logic                 r_pv, r_pzero;
    logic signed [XW-1:0] r_px, r_py;
    logic signed [ZW-1:0] r_pz;

    logic                 r_v    [CORDIC_STEPS];
    logic                 r_zero [CORDIC_STEPS];
    logic signed [XW-1:0] r_x    [CORDIC_STEPS];
    logic signed [XW-1:0] r_y    [CORDIC_STEPS];
    logic signed [ZW-1:0] r_z    [CORDIC_STEPS];

    logic                    r_ov;
    logic signed [ANG_W-1:0] r_ang;
    logic signed [ZW-1:0]    n_round;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pzero <= (i_x == '0) && (i_y == '0);
        if (i_x < 0) begin
            if (i_y >= 0) begin
                r_px <= i_y;
                r_py <= -i_x;
                r_pz <= HALF_PI_Q16;
            end else begin
                r_px <= -i_y;
                r_py <= i_x;
                r_pz <= -HALF_PI_Q16;
            end
        end else begin
            r_px <= i_x;
            r_py <= i_y;
            r_pz <= '0;
        end
    end

    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_iter
        logic                 v_in, zero_in;
        logic signed [XW-1:0] x_in, y_in, dx, dy;
        logic signed [ZW-1:0] z_in;

        if (s == 0) begin : g_first
            assign v_in    = r_pv;
            assign zero_in = r_pzero;
            assign x_in    = r_px;
            assign y_in    = r_py;
            assign z_in    = r_pz;
        end else begin : g_next
            assign v_in    = r_v[s-1];
            assign zero_in = r_zero[s-1];
            assign x_in    = r_x[s-1];
            assign y_in    = r_y[s-1];
            assign z_in    = r_z[s-1];
        end

        assign dx = y_in >>> s;
        assign dy = x_in >>> s;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else begin
                r_v[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_zero[s] <= zero_in;
            if (y_in > 0) begin
                r_x[s] <= x_in + dx;
                r_y[s] <= y_in - dy;
                r_z[s] <= z_in + ATAN_TAB[s];
            end else begin
                r_x[s] <= x_in - dx;
                r_y[s] <= y_in + dy;
                r_z[s] <= z_in - ATAN_TAB[s];
            end
        end
    end

    assign n_round = (r_z[CORDIC_STEPS-1] + ZW'(8)) >>> 4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[CORDIC_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_zero[CORDIC_STEPS-1]) begin
            r_ang <= '0;
        end else begin
            r_ang <= ANG_W'(n_round);
        end
    end

    assign o_vld = r_ov;
    assign o_ang = r_ang;

endmodule

>>> rtl/q2e_level.sv
// Window mapping of one angle onto a level, with a pipelined restoring divider.
module q2e_level #(
    parameter int LEVEL_SCALE = q2e_pkg::LEVEL_SCALE_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_vld,
    input  logic signed [q2e_pkg::ANG_W-1:0]   i_ang,
    input  logic signed [q2e_pkg::LIM_W-1:0]   i_lo,
    input  logic signed [q2e_pkg::LIM_W-1:0]   i_hi,
    output logic                               o_vld,
    output logic [q2e_pkg::LEVEL_W-1:0]        o_level
);
    import q2e_pkg::*;

    localparam int SW  = $clog2(LEVEL_SCALE + 1);
    localparam int NW  = DIFF_W + SW;
    localparam int LVW = (SW > LEVEL_W) ? SW : LEVEL_W;
    localparam logic [SW-1:0] TOP = SW'(LEVEL_SCALE - 1);

    logic signed [ANG_W:0] ext_a, ext_lo, ext_hi, n_diff, n_span;
    t_win                  n_sel;

    logic              r0_vld, r1_vld;
    t_win              r0_sel, r1_sel;
    logic [DIFF_W-1:0] r0_diff, r0_span, r1_span;
    logic [NW-1:0]     r1_num;

    logic              r_v    [SW];
    t_win              r_sel  [SW];
    logic [DIFF_W-1:0] r_span [SW];
    logic [NW-1:0]     r_rem  [SW];
    logic [SW-1:0]     r_q    [SW];

    logic [SW-1:0]        n_sat, n_val;
    logic [LVW-1:0]       n_ext;
    logic                 r_ov;
    logic [LEVEL_W-1:0]   r_level;

    always_comb begin
        ext_a  = (ANG_W + 1)'(i_ang);
        ext_lo = (ANG_W + 1)'(i_lo);
        ext_hi = (ANG_W + 1)'(i_hi);
        n_diff = ext_a - ext_lo;
        n_span = ext_hi - ext_lo;
        if ((ext_a >= ext_lo) && (ext_a <= ext_hi)) begin
            n_sel = (n_span == '0) ? WIN_TOP : WIN_DIV;
        end else if (ext_a > ext_hi) begin
            n_sel = WIN_TOP;
        end else begin
            n_sel = WIN_LOW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
        end else begin
            r0_vld <= i_vld;
            r1_vld <= r0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_sel  <= n_sel;
        r0_diff <= n_diff[DIFF_W-1:0];
        r0_span <= n_span[DIFF_W-1:0];
        r1_sel  <= r0_sel;
        r1_span <= r0_span;
        r1_num  <= {{SW{1'b0}}, r0_diff} * NW'(LEVEL_SCALE);
    end

    for (genvar k = 0; k < SW; k++) begin : g_div
        logic              v_in;
        t_win              sel_in;
        logic [DIFF_W-1:0] span_in;
        logic [NW-1:0]     rem_in, dsh;
        logic [SW-1:0]     q_in;

        if (k == 0) begin : g_first
            assign v_in    = r1_vld;
            assign sel_in  = r1_sel;
            assign span_in = r1_span;
            assign rem_in  = r1_num;
            assign q_in    = '0;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign sel_in  = r_sel[k-1];
            assign span_in = r_span[k-1];
            assign rem_in  = r_rem[k-1];
            assign q_in    = r_q[k-1];
        end

        assign dsh = {{SW{1'b0}}, span_in} << (SW - 1 - k);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_sel[k]  <= sel_in;
            r_span[k] <= span_in;
            if (rem_in >= dsh) begin
                r_rem[k] <= rem_in - dsh;
                r_q[k]   <= q_in | (SW'(1) << (SW - 1 - k));
            end else begin
                r_rem[k] <= rem_in;
                r_q[k]   <= q_in;
            end
        end
    end

    always_comb begin
        n_sat = (r_q[SW-1] > TOP) ? TOP : r_q[SW-1];
        case (r_sel[SW-1])
            WIN_DIV: n_val = n_sat;
            WIN_TOP: n_val = TOP;
            default: n_val = '0;
        endcase
        n_ext = LVW'(n_val);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[SW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_level <= n_ext[LEVEL_W-1:0];
    end

    assign o_vld   = r_ov;
    assign o_level = r_level;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the quaternion to Euler control level block.
`timescale 1ns / 1ps
module testbench;
    import q2e_pkg::*;

    localparam longint UNIT_Q28 = 64'sd268435456;
    localparam longint SCALE = 100;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 80;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 330;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        logic [LEVEL_W-1:0] roll;
        logic [LEVEL_W-1:0] pitch;
        logic [LEVEL_W-1:0] yaw;
    } t_levels;

    typedef struct {
        logic signed [QUAT_W-1:0] w;
        logic signed [QUAT_W-1:0] x;
        logic signed [QUAT_W-1:0] y;
        logic signed [QUAT_W-1:0] z;
        bit typed;
        t_levels lv;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [LIM_W-1:0] i_cfg_data = '0;
    logic signed [QUAT_W-1:0] i_quat_w = '0;
    logic signed [QUAT_W-1:0] i_quat_x = '0;
    logic signed [QUAT_W-1:0] i_quat_y = '0;
    logic signed [QUAT_W-1:0] i_quat_z = '0;
    logic o_done;
    logic [LEVEL_W-1:0] o_roll_level;
    logic [LEVEL_W-1:0] o_pitch_level;
    logic [LEVEL_W-1:0] o_yaw_level;

    t_cfg windows = CFG_RESET;
    t_levels pending_levels[$];
    int mismatches = 0;
    int requests = 0;
    int results = 0;
    int quiet_cycles = 0;
    bit allow_idle = 1'b1;

    quaternion_to_euler_levels u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_quat_w(i_quat_w), .i_quat_x(i_quat_x), .i_quat_y(i_quat_y),
        .i_quat_z(i_quat_z), .o_done(o_done), .o_roll_level(o_roll_level),
        .o_pitch_level(o_pitch_level), .o_yaw_level(o_yaw_level)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_row directed[] = '{
        '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{7'd50, 7'd30, 7'd99}},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{7'd50, 7'd30, 7'd99}},
        '{-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{7'd50, 7'd30, 7'd99}},
        '{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 1'b0, '{7'd0, 7'd0, 7'd0}},
        '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 1'b0, '{7'd0, 7'd0, 7'd0}},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b0, '{7'd0, 7'd0, 7'd0}},
        '{16'sd0, -16'sd16384, 16'sd0, 16'sd0, 1'b0, '{7'd0, 7'd0, 7'd0}},
        '{16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 1'b0, '{7'd0, 7'd0, 7'd0}},
        '{16'sd16384, 16'sd0, -16'sd16384, 16'sd0, 1'b0, '{7'd0, 7'd0, 7'd0}},
        '{16'sd11585, 16'sd11585, 16'sd0, 16'sd0, 1'b0, '{7'd0, 7'd0, 7'd0}},
        '{16'sd11585, -16'sd11585, 16'sd0, 16'sd0, 1'b0, '{7'd0, 7'd0, 7'd0}},
        '{16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 1'b0, '{7'd0, 7'd0, 7'd0}},
        '{16'sd11585, 16'sd0, 16'sd0, -16'sd11585, 1'b0, '{7'd0, 7'd0, 7'd0}},
        '{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 1'b0, '{7'd0, 7'd0, 7'd0}},
        '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, '{7'd0, 7'd0, 7'd0}},
        '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '{7'd0, 7'd0, 7'd0}},
        '{16'sh8000, 16'sh7FFF, 16'sh5555, 16'shAAAA, 1'b0, '{7'd0, 7'd0, 7'd0}},
        '{-16'sd8192, 16'sd8192, -16'sd8192, -16'sd8192, 1'b0, '{7'd0, 7'd0, 7'd0}}
    };

    function automatic longint vector_angle(longint y0, longint x0);
        longint x, y, z, t, dx, dy;
        x = x0;
        y = y0;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = longint'(HALF_PI_Q16);
            end else begin
                x = -y;
                y = t;
                z = -longint'(HALF_PI_Q16);
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx;
                y -= dy;
                z += longint'(ATAN_TAB[i]);
            end else begin
                x -= dx;
                y += dy;
                z -= longint'(ATAN_TAB[i]);
            end
        end
        return (z + 8) >>> 4;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n0);
        longint unsigned n, r, b;
        n = n0;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [LEVEL_W-1:0] window_level(longint a, longint lo, longint hi);
        longint v;
        if (a >= lo && a <= hi) begin
            if (hi == lo) v = SCALE - 1;
            else begin
                v = ((a - lo) * SCALE) / (hi - lo);
                if (v > SCALE - 1) v = SCALE - 1;
            end
        end else if (a > hi) begin
            v = SCALE - 1;
        end else begin
            v = 0;
        end
        return v[LEVEL_W-1:0];
    endfunction

    function automatic t_levels predict_levels(logic signed [QUAT_W-1:0] qw,
            logic signed [QUAT_W-1:0] qx, logic signed [QUAT_W-1:0] qy,
            logic signed [QUAT_W-1:0] qz);
        longint w, x, y, z, t, at, roll, pitch, yaw;
        longint unsigned root;
        t_levels res;
        w = longint'(qw);
        x = longint'(qx);
        y = longint'(qy);
        z = longint'(qz);
        roll = -vector_angle(2 * (w * x + y * z), UNIT_Q28 - 2 * (x * x + y * y));
        t = 2 * (w * y - z * x);
        if (t > UNIT_Q28) t = UNIT_Q28;
        if (t < -UNIT_Q28) t = -UNIT_Q28;
        at = (t < 0) ? -t : t;
        root = floor_sqrt((64'd1 << 56) - longint'(at * at));
        pitch = vector_angle(t, longint'(root));
        yaw = -vector_angle(2 * (w * z + x * y), UNIT_Q28 - 2 * (y * y + z * z));
        res.roll = window_level(roll, longint'(windows.roll_lo), longint'(windows.roll_hi));
        res.pitch = window_level(pitch, longint'(windows.pitch_lo),
            longint'(windows.pitch_hi));
        res.yaw = window_level(yaw, longint'(windows.yaw_lo), longint'(windows.yaw_hi));
        return res;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LIM_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ROLL_LO: windows.roll_lo = data;
            REG_ROLL_HI: windows.roll_hi = data;
            REG_PITCH_LO: windows.pitch_lo = data[PLIM_W-1:0];
            REG_PITCH_HI: windows.pitch_hi = data[PLIM_W-1:0];
            REG_YAW_LO: windows.yaw_lo = data;
            REG_YAW_HI: windows.yaw_hi = data;
            default: ;
        endcase
    endtask

    task automatic write_windows(int rl, int rh, int pl, int ph, int yl, int yh);
        write_reg(REG_ROLL_LO, rl[LIM_W-1:0]);
        write_reg(REG_ROLL_HI, rh[LIM_W-1:0]);
        write_reg(REG_PITCH_LO, pl[LIM_W-1:0]);
        write_reg(REG_PITCH_HI, ph[LIM_W-1:0]);
        write_reg(REG_YAW_LO, yl[LIM_W-1:0]);
        write_reg(REG_YAW_HI, yh[LIM_W-1:0]);
    endtask

    task automatic issue(logic signed [QUAT_W-1:0] w, logic signed [QUAT_W-1:0] x,
            logic signed [QUAT_W-1:0] y, logic signed [QUAT_W-1:0] z,
            bit typed, t_levels lv);
        start <= 1'b1;
        i_quat_w <= w;
        i_quat_x <= x;
        i_quat_y <= y;
        i_quat_z <= z;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_levels.push_back(typed ? lv : predict_levels(w, x, y, z));
        requests++;
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic random_request();
        logic signed [QUAT_W-1:0] q[4];
        real c[4];
        real norm;
        int kind;
        t_levels none;
        none = '{7'd0, 7'd0, 7'd0};
        kind = $urandom_range(0, 9);
        norm = 0.0;
        for (int i = 0; i < 4; i++) begin
            q[i] = QUAT_W'($urandom_range(0, 32768) - 16384);
            if (kind == 9) q[i] = QUAT_W'($urandom());
            c[i] = q[i];
            norm += c[i] * c[i];
        end
        if (kind < 7 && norm > 1.0) begin
            norm = $sqrt(norm);
            for (int i = 0; i < 4; i++) q[i] = QUAT_W'($rtoi(c[i] * 16384.0 / norm));
        end
        issue(q[0], q[1], q[2], q[3], 1'b0, none);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_levels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            results++;
            if (pending_levels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: %0d %0d %0d",
                    o_roll_level, o_pitch_level, o_yaw_level);
            end else begin
                t_levels e;
                e = pending_levels.pop_front();
                if (e.roll !== o_roll_level || e.pitch !== o_pitch_level ||
                        e.yaw !== o_yaw_level) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                            e.roll, e.pitch, e.yaw, o_roll_level, o_pitch_level,
                            o_yaw_level);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL quaternion_to_euler_levels");
            $finish;
        end
    end

    initial begin
        t_levels none;
        none = '{7'd0, 7'd0, 7'd0};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i])
            issue(directed[i].w, directed[i].x, directed[i].y, directed[i].z,
                directed[i].typed, directed[i].lv);
        for (int ph = 0; ph < PHASES; ph++) begin
            allow_idle = (ph != PHASES - 1);
            if (ph > 0) drain();
            case (ph)
                1: begin
                    write_windows(-12868, 12868, -6434, 6434, -12868, 12868);
                    write_reg(REG_SPARE_LO, LIM_W'($urandom()));
                    write_reg(REG_SPARE_HI, LIM_W'($urandom()));
                end
                2: write_windows(4506, -4506, 0, 0, -100, 0);
                3: write_windows($urandom_range(0, 12868) - 12868, $urandom_range(0, 12868),
                    $urandom_range(0, 6434) - 6434, $urandom_range(0, 6434),
                    $urandom_range(0, 12868) - 12868, $urandom_range(0, 12868));
                4: write_windows($urandom(), $urandom(), $urandom(), $urandom(),
                    $urandom(), $urandom());
                5: write_windows(-4506, 4506, -1229, 2867, -6144, -819);
                default: ;
            endcase
            if (ph > 0) begin
                issue(16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0, none);
                issue(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, none);
            end
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (ph != PHASES - 1) allow_idle = (k % 110) < 70;
                random_request();
            end
        end
        drain();
        $display("Covered %0d requests and %0d results over %0d window settings,",
            requests, results, PHASES);
        $display("including inverted, zero-width and full-range windows; %0d mismatches.",
            mismatches);
        if (mismatches == 0) $display("PASS quaternion_to_euler_levels");
        else $display("FAIL quaternion_to_euler_levels");
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl
rtl/q2e_pkg.sv
rtl/q2e_front.sv
rtl/q2e_isqrt.sv
rtl/q2e_cordic.sv
rtl/q2e_level.sv
rtl/quaternion_to_euler_levels.sv
tb/testbench.sv
